>>> rtl/ordered_list_insert_and_index_read_unit_defines.svh
// Assertion helpers shared by the RTL.
`ifndef ORDERED_LIST_INSERT_AND_INDEX_READ_UNIT_DEFINES_SVH
`define ORDERED_LIST_INSERT_AND_INDEX_READ_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLIU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("oliu: check failed");

// Next-cycle implication, checked outside reset.
`define OLIU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("oliu: check failed");

`endif

>>> rtl/oliu_pkg.sv
package oliu_pkg;

    localparam int MAX_ELEMENTS_DEF = 256;
    localparam int POS_W            = 9;
    localparam int VAL_W            = 32;
    localparam int ST_W             = 2;

    localparam logic ACT_READ   = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [ST_W-1:0] STAT_OK      = 2'd0;
    localparam logic [ST_W-1:0] STAT_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] STAT_FULL    = 2'd2;

    typedef struct packed {
        logic                    action;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic [POS_W-1:0]        length;
    } t_out;

endpackage

>>> rtl/oliu_ram.sv
module oliu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ordered_list_insert_and_index_read_unit.sv
// Ordered list of signed 32-bit values held as linked nodes in two RAMs.
// Input channel (i_in_valid / o_in_stall / i_in_data): one item per transfer,
// either a read of the value at a position or an insert at a position.
// Output channel (o_out_valid / i_out_stall / o_out_data): exactly one result
// per item, with the value read, a status code and the list length after it.
// One item at a time: o_in_stall is high from acceptance until the result is
// loaded into the output register. A read at position p, or a middle insert at
// position p, walks the link RAM one node per cycle, so the time an item takes
// grows with p; head, tail and rejected items need no walk. The link RAM read
// port, with its registered read, sets the walk rate.
// The output register holds a result while i_out_stall is high; the next item
// is accepted meanwhile and its result waits in the sequencer until the
// register frees up.
// Reset (synchronous, active low) empties the list at once; the node RAMs need
// no clearing since only written nodes are ever reached.
`include "ordered_list_insert_and_index_read_unit_defines.svh"

module ordered_list_insert_and_index_read_unit #(
    parameter int MAX_ELEMENTS = oliu_pkg::MAX_ELEMENTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  oliu_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output oliu_pkg::t_out o_out_data
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int POS_W = oliu_pkg::POS_W;
    localparam int VAL_W = oliu_pkg::VAL_W;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] MAX_X = CMP_W'(MAX_ELEMENTS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_VRD    = 3'd3;
    localparam logic [2:0] ST_LNK    = 3'd4;
    localparam logic [2:0] ST_LNK2   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // control state
    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // payload
    logic                        r_act, n_act;
    logic [POS_W-1:0]            r_pos, n_pos;
    logic [VAL_W-1:0]            r_val, n_val;
    logic [POS_W-1:0]            r_hops, n_hops;
    logic [IDX_W-1:0]            r_node, n_node;
    logic [IDX_W-1:0]            r_nn, n_nn;
    logic [VAL_W-1:0]            r_rv, n_rv;
    logic [oliu_pkg::ST_W-1:0]   r_st, n_st;
    oliu_pkg::t_out              r_out, n_out;

    // RAM ports
    logic             lk_we, vl_we;
    logic [IDX_W-1:0] lk_waddr, lk_raddr, vl_waddr, vl_raddr;
    logic [IDX_W-1:0] lk_wdata, lk_rdata;
    logic [VAL_W-1:0] vl_wdata, vl_rdata;

    logic             in_xfer;
    logic             out_free;
    logic [CMP_W-1:0] pos_x, cnt_x;
    logic [IDX_W-1:0] nn_now;

    oliu_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_links (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    oliu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_values (
        .i_clk   (i_clk),
        .i_we    (vl_we),
        .i_waddr (vl_waddr),
        .i_wdata (vl_wdata),
        .i_raddr (vl_raddr),
        .o_rdata (vl_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign pos_x  = CMP_W'(r_pos);
    assign cnt_x  = CMP_W'(r_count);
    assign nn_now = r_count[IDX_W-1:0];

    // walk: each cycle the link just read becomes the next read address
    assign lk_raddr = (r_state == ST_DECIDE) ? r_head : lk_rdata;
    assign vl_raddr = (r_state == ST_DECIDE) ? r_head : lk_rdata;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_act       = r_act;
        n_pos       = r_pos;
        n_val       = r_val;
        n_hops      = r_hops;
        n_node      = r_node;
        n_nn        = r_nn;
        n_rv        = r_rv;
        n_st        = r_st;
        n_out       = r_out;
        lk_we       = 1'b0;
        lk_waddr    = r_nn;
        lk_wdata    = r_node;
        vl_we       = 1'b0;
        vl_waddr    = nn_now;
        vl_wdata    = r_val;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_act   = i_in_data.action;
                    n_pos   = i_in_data.position;
                    n_val   = i_in_data.item_value;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_act == oliu_pkg::ACT_READ) begin
                    if (pos_x >= cnt_x) begin
                        n_rv    = '1;
                        n_st    = oliu_pkg::STAT_BAD_POS;
                        n_state = ST_OUT;
                    end else begin
                        n_st = oliu_pkg::STAT_OK;
                        if (r_pos == '0) begin
                            n_state = ST_VRD;
                        end else begin
                            n_hops  = r_pos;
                            n_state = ST_WALK;
                        end
                    end
                end else begin
                    n_rv = '0;
                    if (pos_x > cnt_x) begin
                        n_st    = oliu_pkg::STAT_BAD_POS;
                        n_state = ST_OUT;
                    end else if (cnt_x == MAX_X) begin
                        n_st    = oliu_pkg::STAT_FULL;
                        n_state = ST_OUT;
                    end else begin
                        n_st    = oliu_pkg::STAT_OK;
                        vl_we   = 1'b1;
                        n_nn    = nn_now;
                        n_count = r_count + CNT_W'(1);
                        if (r_count == '0) begin
                            n_head  = nn_now;
                            n_tail  = nn_now;
                            n_state = ST_OUT;
                        end else if (r_pos == '0) begin
                            lk_we    = 1'b1;
                            lk_waddr = nn_now;
                            lk_wdata = r_head;
                            n_head   = nn_now;
                            n_state  = ST_OUT;
                        end else if (pos_x == cnt_x) begin
                            lk_we    = 1'b1;
                            lk_waddr = r_tail;
                            lk_wdata = nn_now;
                            n_tail   = nn_now;
                            n_state  = ST_OUT;
                        end else if (r_pos == POS_W'(1)) begin
                            // predecessor is the head, its link read is issued now
                            n_node  = r_head;
                            n_state = ST_LNK;
                        end else begin
                            n_hops  = r_pos - POS_W'(1);
                            n_state = ST_WALK;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (r_hops == POS_W'(1)) begin
                    n_node  = lk_rdata;
                    n_state = (r_act == oliu_pkg::ACT_READ) ? ST_VRD : ST_LNK;
                end else begin
                    n_hops = r_hops - POS_W'(1);
                end
            end
            ST_VRD: begin
                n_rv    = vl_rdata;
                n_state = ST_OUT;
            end
            ST_LNK: begin
                // new node takes over the predecessor's successor
                lk_we    = 1'b1;
                lk_waddr = r_nn;
                lk_wdata = lk_rdata;
                n_state  = ST_LNK2;
            end
            ST_LNK2: begin
                lk_we    = 1'b1;
                lk_waddr = r_node;
                lk_wdata = r_nn;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.read_value = r_rv;
                    n_out.status     = r_st;
                    n_out.length     = cnt_x[POS_W-1:0];
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_hops <= n_hops;
        r_node <= n_node;
        r_nn   <= n_nn;
        r_rv   <= n_rv;
        r_st   <= n_st;
        r_out  <= n_out;
    end

    `OLIU_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, cnt_x <= MAX_X)
    `OLIU_ASSERT_NEXT(a_accept_decides, i_clk, i_rst_n, in_xfer, r_state == ST_DECIDE)
    `OLIU_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == ST_OUT) && out_free,
                      r_out_valid && (r_state == ST_IDLE))
    `OLIU_ASSERT_SAME(a_full_only_at_max, i_clk, i_rst_n,
                      (r_state == ST_OUT) && (r_st == oliu_pkg::STAT_FULL), cnt_x == MAX_X)

endmodule
